### sv/assert_macros.svh
// Assertion helpers shared by the RTL files. Each use starts on its own line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/modexp_pkg.sv
package modexp_pkg;

    // Width of the base value, the exponents and the residue field.
    localparam int unsigned WORD_W = 32;
    // Width of the configuration register index.
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd2;

    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] base_value;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] residue;
        logic              fault;
    } t_out_item;

    // Status of the shared modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

endpackage

### sv/modular_exponentiation.sv
// Modular exponentiation unit: each request carries a base and a request type, and
// one result returns base^e mod n. An encrypt request uses the public exponent on
// the low byte of the base and returns the full residue; a decrypt request uses the
// private exponent on the full 32-bit base and returns only the low 8 bits of the
// residue. A zero modulus returns residue 0 with fault set; a zero exponent returns
// 1. The modulus keeps its low MOD_BITS bits. Requests are handled one at a time:
// o_in_stall is low only while the unit is idle, which includes the time a finished
// result waits in the output register. The work is done by one bit-serial modular
// multiplier; the sequencer passes through ST_NEXT after each product. A request
// costs one reduction of the base, one squaring per exponent bit below the highest
// set bit, and one multiplication per set bit. With a zero modulus or zero exponent
// no product is formed: the unit goes straight to ST_DONE and loads the result
// register from there. Configuration must be written only while the unit is idle;
// the unit itself does not enforce this.
`include "assert_macros.svh"

module modular_exponentiation import modexp_pkg::*; #(
    parameter int unsigned MOD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    // Request channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_req,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_res
);

    // Configuration registers.
    logic [MOD_BITS-1:0] r_mod;
    logic [WORD_W-1:0]   r_pub_exp;
    logic [WORD_W-1:0]   r_priv_exp;

    // Sequencer state and working registers.
    t_state              r_state, n_state;
    logic [MOD_BITS-1:0] r_sq, n_sq;
    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [WORD_W-1:0]   r_exp, n_exp;
    logic                r_dec, n_dec;
    logic                r_fault, n_fault;

    // Output register.
    logic                r_out_valid;
    t_out_item           r_out;

    // Shared multiplier hookup.
    logic                mm_start;
    logic [MOD_BITS-1:0] mm_a;
    logic [WORD_W-1:0]   mm_b;
    t_mm_stat            mm_stat;
    logic [MOD_BITS-1:0] mm_product;

    logic                in_accept;
    logic                out_free;
    logic                load_out;
    logic [MOD_BITS-1:0] one_mod;
    logic [WORD_W-1:0]   req_exp;
    logic [WORD_W-1:0]   req_base;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // 1 mod n, which is 0 only when the modulus is one.
    assign one_mod = (r_mod == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

    // Encrypt works on the low byte of the base; decrypt on the whole word.
    assign req_exp  = (i_in_req.req_type == REQ_DECRYPT) ? r_priv_exp : r_pub_exp;
    assign req_base = (i_in_req.req_type == REQ_DECRYPT) ? i_in_req.base_value
                                                         : WORD_W'(i_in_req.base_value[7:0]);

    modexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_a       (mm_a),
        .i_b       (mm_b),
        .i_m       (r_mod),
        .o_stat    (mm_stat),
        .o_product (mm_product)
    );

    // Next-state logic. The exponent is consumed LSB first: a set bit costs a
    // multiply into the accumulator, and every step to the next bit costs a squaring.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if ((r_mod == '0) || (req_exp == '0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_stat.done) begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                priority if (r_exp == '0) begin
                    n_state = ST_DONE;
                end else if (r_exp[0]) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_SQR;
                end
            end
            ST_MUL: begin
                if (mm_stat.done) begin
                    n_state = ST_NEXT;
                end
            end
            ST_SQR: begin
                if (mm_stat.done) begin
                    n_state = ST_NEXT;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control and working register updates.
    always_comb begin
        mm_start = 1'b0;
        mm_a     = r_acc;
        mm_b     = WORD_W'(r_sq);
        n_sq     = r_sq;
        n_acc    = r_acc;
        n_exp    = r_exp;
        n_dec    = r_dec;
        n_fault  = r_fault;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_dec   = (i_in_req.req_type == REQ_DECRYPT);
                    n_exp   = req_exp;
                    n_fault = 1'b0;
                    priority if (r_mod == '0) begin
                        n_fault = 1'b1;
                        n_acc   = '0;
                    end else if (req_exp == '0) begin
                        n_acc = MOD_BITS'(1);
                    end else begin
                        // Reduce the base: (1 mod n) * base mod n.
                        n_acc    = one_mod;
                        mm_start = 1'b1;
                        mm_a     = one_mod;
                        mm_b     = req_base;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_stat.done) begin
                    n_sq = mm_product;
                end
            end
            ST_NEXT: begin
                if (r_exp != '0) begin
                    mm_start = 1'b1;
                    if (r_exp[0]) begin
                        mm_a = r_acc;
                    end else begin
                        mm_a = r_sq;
                    end
                end
            end
            ST_MUL: begin
                if (mm_stat.done) begin
                    n_acc    = mm_product;
                    n_exp[0] = 1'b0;
                end
            end
            ST_SQR: begin
                if (mm_stat.done) begin
                    n_sq  = mm_product;
                    n_exp = {1'b0, r_exp[WORD_W-1:1]};
                end
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mod       <= MOD_BITS'(1);
            r_pub_exp   <= WORD_W'(1);
            r_priv_exp  <= WORD_W'(1);
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODULUS:     r_mod      <= i_cfg_data[MOD_BITS-1:0];
                    CFG_PUBLIC_EXP:  r_pub_exp  <= i_cfg_data;
                    CFG_PRIVATE_EXP: r_priv_exp <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq    <= n_sq;
        r_acc   <= n_acc;
        r_exp   <= n_exp;
        r_dec   <= n_dec;
        r_fault <= n_fault;
        if (load_out) begin
            r_out.fault <= r_fault;
            if (r_dec) begin
                r_out.residue <= WORD_W'(r_acc[7:0]);
            end else begin
                r_out.residue <= WORD_W'(r_acc);
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    `ASSERT_SAME(a_start_when_free, i_clk, i_rst_n, mm_start, !mm_stat.busy)
    `ASSERT_SAME(a_idle_unit_quiet, i_clk, i_rst_n, r_state == ST_IDLE, !mm_stat.busy)
    `ASSERT_NEXT(a_done_loads_out, i_clk, i_rst_n, (r_state == ST_DONE) && out_free,
        r_out_valid && (r_state == ST_IDLE))

endmodule

### sv/modexp_mulmod.sv
`include "assert_macros.svh"

// Bit-serial interleaved modular multiplier: product = a * b mod m.
// One bit of b is consumed per cycle, MSB first. Requires a < m and m > 0.
module modexp_mulmod import modexp_pkg::*; #(
    parameter int unsigned MOD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_a,
    input  logic [WORD_W-1:0]   i_b,
    input  logic [MOD_BITS-1:0] i_m,
    output t_mm_stat            o_stat,
    output logic [MOD_BITS-1:0] o_product
);

    localparam int unsigned CNT_W = $clog2(WORD_W + 1);
    localparam int unsigned SUM_W = MOD_BITS + 2;

    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS-1:0] r_a;
    logic [MOD_BITS-1:0] r_m;
    logic [WORD_W-1:0]   r_b;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m_one;
    logic [SUM_W-1:0] m_two;

    // Sum stays below 3m, so at most two subtractions of m are needed;
    // both candidates are formed side by side and one is selected.
    always_comb begin
        m_one = SUM_W'(r_m);
        m_two = SUM_W'({r_m, 1'b0});
        sum   = SUM_W'({r_acc, 1'b0}) + (r_b[WORD_W-1] ? SUM_W'(r_a) : '0);
        if (sum >= m_two) begin
            n_acc = MOD_BITS'(sum - m_two);
        end else if (sum >= m_one) begin
            n_acc = MOD_BITS'(sum - m_one);
        end else begin
            n_acc = MOD_BITS'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[WORD_W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_acc;

    `ASSERT_SAME(a_acc_reduced, i_clk, i_rst_n, r_busy || r_done, r_acc < r_m)
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done)
    `ASSERT_NEXT(a_busy_counts, i_clk, i_rst_n, r_busy && !i_start && (r_cnt != CNT_W'(1)),
        r_busy && (r_cnt == $past(r_cnt) - 1'b1))

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import modexp_pkg::*;

    // The unit is built at its full modulus width.
    localparam int unsigned MOD_BITS = 32;
    localparam logic [63:0] MOD_MASK = (64'd1 << MOD_BITS) - 64'd1;

    // Index 3 is not a register. Writes to it must leave the key untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // The limit covers the slowest request plus a stall burst on each side.
    // There are about 270 requests, so the limit leaves a wide margin.
    localparam longint unsigned CYCLE_LIMIT = 64'd3_000_000;
    localparam int unsigned RANDOM_REQUESTS = 250;
    // Idling stops once this many random requests remain.
    localparam int unsigned QUIET_TAIL = 40;

    // The scoreboard keeps its own copy of the key registers. It predicts the
    // residue of each accepted request. It compares every returned result,
    // field by field, against the oldest prediction still outstanding.
    class residue_checker;
        logic [WORD_W-1:0] modulus     = 32'd1;
        logic [WORD_W-1:0] public_exp  = 32'd1;
        logic [WORD_W-1:0] private_exp = 32'd1;
        t_out_item         pending_residues[$];
        int unsigned       failures = 0;
        int unsigned       checked  = 0;
        int unsigned       faults   = 0;
        int unsigned       decrypts = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                CFG_MODULUS:     modulus     = data & MOD_MASK[WORD_W-1:0];
                CFG_PUBLIC_EXP:  public_exp  = data;
                CFG_PRIVATE_EXP: private_exp = data;
                default: ;
            endcase
        endfunction

        // Square-and-multiply over all 32 exponent bits. The products use
        // 64 bits, so no reduction overflows.
        function logic [WORD_W-1:0] power_mod(logic [WORD_W-1:0] b, logic [WORD_W-1:0] e,
                                              logic [WORD_W-1:0] m);
            logic [63:0] acc;
            logic [63:0] sq;
            logic [63:0] m64;
            if (e == 0) begin
                return 32'd1;
            end
            m64 = 64'(m);
            sq  = 64'(b) % m64;
            acc = 64'd1 % m64;
            for (int k = 0; k < WORD_W; k++) begin
                if (e[k]) begin
                    acc = (acc * sq) % m64;
                end
                sq = (sq * sq) % m64;
            end
            return acc[WORD_W-1:0];
        endfunction

        function t_out_item residue_of(t_in_item req);
            t_out_item res;
            res.fault = 1'b0;
            if (modulus == 0) begin
                res.residue = '0;
                res.fault   = 1'b1;
            end else if (req.req_type == REQ_DECRYPT) begin
                res.residue = power_mod(req.base_value, private_exp, modulus) & 32'hFF;
            end else begin
                res.residue = power_mod({24'd0, req.base_value[7:0]}, public_exp, modulus);
            end
            return res;
        endfunction

        function void note_request(t_in_item req);
            if (req.req_type == REQ_DECRYPT) begin
                decrypts++;
            end
            pending_residues.push_back(residue_of(req));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_residues.size() == 0) begin
                failures++;
                $error("result with no request outstanding: residue %08h fault %0b",
                       got.residue, got.fault);
                return;
            end
            want = pending_residues.pop_front();
            checked++;
            if (want.fault) begin
                faults++;
            end
            if (got.residue !== want.residue) begin
                failures++;
                $error("residue mismatch: expected %08h, actual %08h",
                       want.residue, got.residue);
            end
            if (got.fault !== want.fault) begin
                failures++;
                $error("fault mismatch: expected %0b, actual %0b", want.fault, got.fault);
            end
        endfunction
    endclass

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [WORD_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_req   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_res;

    residue_checker  board = new();
    bit              idle_on = 1'b1;
    int unsigned     stall_left = 0;
    longint unsigned cycle_count = 0;
    int unsigned     key_settings = 0;

    modular_exponentiation #(
        .MOD_BITS(MOD_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_res  (out_res)
    );

    always #5 i_clk = ~i_clk;

    // The result side applies back-pressure in random bursts.
    // A new burst can start on any cycle while idling is on. It can fall while the unit is busy or
    // while a finished result waits in the output register.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 14);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // This block checks results and enforces the cycle limit. Signals are
    // read right after the edge, so each one shows its value at that edge.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timed out after %0d cycles, %0d results outstanding",
                   cycle_count, board.pending_residues.size());
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n && out_valid && !out_stall) begin
            board.check_result(out_res);
        end
    end

    // Each write is taken at the next edge. The enable stays high so that
    // back-to-back writes never lower and raise it in the same step. The
    // caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // This task loads a full key. It can also write the unused index, which
    // must have no effect on the predictions that follow.
    task automatic load_key(input logic [WORD_W-1:0] n, input logic [WORD_W-1:0] pub,
                            input logic [WORD_W-1:0] priv, input bit poke_unused);
        write_reg(CFG_MODULUS, n);
        write_reg(CFG_PUBLIC_EXP, pub);
        write_reg(CFG_PRIVATE_EXP, priv);
        if (poke_unused) begin
            write_reg(CFG_UNUSED, $urandom);
        end
        cfg_we <= 1'b0;
        key_settings++;
    endtask

    // This task offers one request and holds it until the unit takes it. Valid
    // stays high after acceptance, so the next request can follow with no
    // bubble. A random idle burst drops valid first. The prediction is recorded
    // here at the edge of acceptance. Then the drain check below never misses
    // a request that is still in flight.
    task automatic send_request(input logic kind, input logic [WORD_W-1:0] base);
        t_in_item req;
        req.req_type   = kind;
        req.base_value = base;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        board.note_request(req);
    endtask

    // The sender holds off until every outstanding result is back. A few
    // more cycles then pass, so that the unit is idle before any key change.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending_residues.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_modulus();
        case ($urandom_range(0, 11))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(2, 255);
            4, 5:    return $urandom_range(2, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Short exponents dominate, because latency grows with the exponent.
    // Full-width ones still appear often enough to use every bit.
    function automatic logic [WORD_W-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0:          return 32'd0;
            1:          return 32'd1;
            2:          return 32'hFFFF_FFFF;
            3, 4, 5, 6: return $urandom_range(2, 255);
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_base(input logic [WORD_W-1:0] n);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return n;
            3:       return n - 32'd1;
            4, 5:    return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [WORD_W-1:0] n;
        int unsigned       sent;
        int unsigned       burst;
        int unsigned       phase;

        sent  = 0;
        phase = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset the modulus and both exponents are one. Every residue
        // is therefore zero.
        send_request(REQ_ENCRYPT, 32'd0);
        send_request(REQ_DECRYPT, 32'hFFFF_FFFF);
        wait_drained();

        // A zero modulus sets the fault flag and returns a zero residue.
        load_key(32'd0, 32'd5, 32'd7, 1'b0);
        send_request(REQ_ENCRYPT, 32'hFF);
        send_request(REQ_DECRYPT, 32'h1234_5678);
        wait_drained();

        // All-ones key: the full 32-bit exponent path at the largest modulus.
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(REQ_ENCRYPT, 32'hFF);
        send_request(REQ_DECRYPT, 32'hFFFF_FFFF);
        send_request(REQ_DECRYPT, 32'hFFFF_FFFE);
        send_request(REQ_ENCRYPT, 32'd0);
        wait_drained();

        // A zero exponent returns one, even when the modulus is one. This phase
        // also writes the unused index.
        load_key(32'd1, 32'd0, 32'd0, 1'b1);
        send_request(REQ_ENCRYPT, 32'h80);
        send_request(REQ_DECRYPT, 32'hFFFF_FFFF);
        wait_drained();

        // A zero public exponent is paired with a decrypt exponent of one. The
        // decrypt residue is then the reduced base.
        load_key(32'd255, 32'd0, 32'd1, 1'b0);
        send_request(REQ_ENCRYPT, 32'd7);
        send_request(REQ_DECRYPT, 32'h0000_FFFF);
        wait_drained();

        // A textbook key pair (n = 61 * 53). Encrypting 65 gives 2790, and
        // decrypting gives 65 back. A base above the modulus is reduced first.
        // On encrypt, the base bits above the low byte are ignored.
        load_key(32'd3233, 32'd17, 32'd2753, 1'b0);
        send_request(REQ_ENCRYPT, 32'd65);
        send_request(REQ_DECRYPT, 32'd2790);
        send_request(REQ_DECRYPT, 32'h8000_0000);
        send_request(REQ_ENCRYPT, 32'h0000_01FF);
        wait_drained();

        // A modulus with only the top bit set.
        load_key(32'h8000_0000, 32'd2, 32'h8000_0000, 1'b0);
        send_request(REQ_ENCRYPT, 32'hFF);
        send_request(REQ_DECRYPT, 32'hFFFF_FFFF);
        send_request(REQ_DECRYPT, 32'd3);
        wait_drained();

        // Random part: a new random key in each phase, then a burst of requests
        // with random bases, many of them near the modulus. In one phase the
        // sender stops halfway until every result is back. The last phases run
        // with no idling on either side.
        while (sent < RANDOM_REQUESTS) begin
            if (sent + QUIET_TAIL >= RANDOM_REQUESTS) begin
                idle_on <= 1'b0;
            end
            n = pick_modulus();
            load_key(n, pick_exponent(), pick_exponent(), $urandom_range(0, 3) == 0);
            burst = $urandom_range(10, 30);
            for (int k = 0; k < burst; k++) begin
                if (phase == 1 && k == burst / 2) begin
                    wait_drained();
                end
                send_request(1'($urandom_range(0, 1)), pick_base(n));
                sent++;
            end
            wait_drained();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        $display("Run covered %0d requests (%0d decrypt) under %0d key settings.",
                 sent + 19, board.decrypts, key_settings);
        $display("%0d results checked, %0d of them zero-modulus faults.",
                 board.checked, board.faults);
        if (board.failures == 0 && board.pending_residues.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/modexp_pkg.sv
sv/modexp_mulmod.sv
sv/modular_exponentiation.sv
sim/tb.sv
